>>> sv/ascc_pkg.sv
// Package for the alarm slot and chime controller: payload structs, constants,
// melody tables and the controller/datapath command and status types. No dependencies.
package ascc_pkg;

    localparam int SLOT_COUNT_DEF    = 8;
    localparam int EXT_COUNT_DEF     = 2;
    localparam int MELODY_LENGTH_DEF = 10;

    localparam logic [9:0]  CHIME_MS     = 10'd75;
    localparam logic [4:0]  NO_HOUR      = 5'd25;
    localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;

    localparam logic [2:0] TONE_REST  = 3'd0;
    localparam logic [2:0] TONE_E6    = 3'd1;
    localparam logic [2:0] TONE_E7    = 3'd2;
    localparam logic [2:0] TONE_PAUSE = 3'd7;

    localparam logic [2:0] REG_BEEP  = 3'd0;
    localparam logic [2:0] REG_BLINK = 3'd1;
    localparam logic [2:0] REG_OPT   = 3'd2;
    localparam logic [2:0] REG_LOW   = 3'd3;
    localparam logic [2:0] REG_MID   = 3'd4;
    localparam logic [2:0] REG_HIGH  = 3'd5;

    typedef struct packed {
        logic        rtc_valid;
        logic [15:0] day_number;
        logic [16:0] second_of_day;
        logic        latching_pin;
        logic        momentary_pin;
        logic        clear_request;
        logic        external_control;
        logic        tone_ready;
        logic        blink_phase;
    } in_word_t;

    typedef struct packed {
        logic       tone_request;
        logic [2:0] tone_code;
        logic [9:0] tone_duration_ms;
        logic       alarm_active;
        logic [7:0] fired_slots;
        logic       blank_display;
        logic       force_bright;
        logic       restore_display;
    } out_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic       load;     // capture input word, prepare
        logic       pre;      // stamp load and clear handling
        logic       scan;     // compare slot scan_idx
        logic [2:0] scan_idx;
        logic       hour;     // hour division step
        logic       fin;      // signalling and result
    } cmd_t;

    typedef struct packed {
        logic hour_done;
    } sts_t;

    function automatic logic [2:0] melody_code(input logic [3:0] i);
        case (i)
            4'd0: melody_code = 3'd6;
            4'd1: melody_code = 3'd3;
            4'd2: melody_code = 3'd0;
            4'd3: melody_code = 3'd3;
            4'd4: melody_code = 3'd4;
            4'd5: melody_code = 3'd3;
            4'd6: melody_code = 3'd0;
            4'd7: melody_code = 3'd5;
            4'd8: melody_code = 3'd6;
            default: melody_code = 3'd0;
        endcase
    endfunction

    function automatic logic [9:0] melody_ms(input logic [3:0] i);
        case (i)
            4'd0: melody_ms = 10'd150;
            4'd1: melody_ms = 10'd300;
            4'd2: melody_ms = 10'd50;
            4'd3: melody_ms = 10'd300;
            4'd4, 4'd5, 4'd6, 4'd7, 4'd8: melody_ms = 10'd150;
            4'd9: melody_ms = 10'd700;
            default: melody_ms = 10'd0;
        endcase
    endfunction

endpackage

>>> sv/ascc_ctrl.sv
// Sequencer of the alarm controller: steps one word through load, stamp/clear,
// slot scan, hour division and finish, then holds the result. Uses ascc_pkg.
module ascc_ctrl #(
    parameter int SLOT_COUNT = ascc_pkg::SLOT_COUNT_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  logic          out_fire,
    input  ascc_pkg::sts_t sts,
    output ascc_pkg::cmd_t cmd,
    output logic          busy,
    output logic          out_valid
);
    import ascc_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_PRE, S_SCAN, S_HOUR, S_FIN, S_OUT} state_t;

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.scan_idx = idx_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = S_PRE;
                end
            end
            S_PRE: begin
                cmd.pre    = 1'b1;
                idx_next   = '0;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                idx_next = idx_reg + 3'd1;
                if (32'(idx_reg) == SLOT_COUNT - 1) state_next = S_HOUR;
            end
            S_HOUR: begin
                cmd.hour = 1'b1;
                if (sts.hour_done) state_next = S_FIN;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_fire) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
endmodule

>>> sv/ascc_dp.sv
// Datapath of the alarm controller: registers, slot compare, acknowledge stamps,
// serial hour divider and signalling logic. Uses ascc_pkg.
module ascc_dp #(
    parameter int SLOT_COUNT    = ascc_pkg::SLOT_COUNT_DEF,
    parameter int EXT_COUNT     = ascc_pkg::EXT_COUNT_DEF,
    parameter int MELODY_LENGTH = ascc_pkg::MELODY_LENGTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ascc_pkg::cmd_t     cmd,
    output ascc_pkg::sts_t     sts,
    input  ascc_pkg::in_word_t in_word,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [63:0]        cfg_wdata,
    output logic [63:0]        cfg_rdata,
    output ascc_pkg::out_word_t out_word
);
    import ascc_pkg::*;

    logic [9:0]  beep_reg, blink_reg;
    logic [1:0]  opt_reg;
    logic [50:0] low_reg, mid_reg;
    logic [33:0] high_reg;

    logic [9:0] used;
    always_comb begin
        used = '0;
        for (int i = 0; i < SLOT_COUNT; i++) used[i] = 1'b1;
        for (int i = 0; i < EXT_COUNT; i++) used[8+i] = 1'b1;
    end
    logic [9:0] beeps, blinks;
    assign beeps  = beep_reg & used;
    assign blinks = blink_reg & used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beep_reg <= '0; blink_reg <= '0; opt_reg <= '0;
            low_reg <= '0; mid_reg <= '0; high_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_BEEP:  beep_reg  <= cfg_wdata[9:0];
                REG_BLINK: blink_reg <= cfg_wdata[9:0];
                REG_OPT:   opt_reg   <= cfg_wdata[1:0];
                REG_LOW:   low_reg   <= cfg_wdata[50:0];
                REG_MID:   mid_reg   <= cfg_wdata[50:0];
                REG_HIGH:  high_reg  <= cfg_wdata[33:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BEEP:  cfg_rdata = {54'd0, beep_reg};
            REG_BLINK: cfg_rdata = {54'd0, blink_reg};
            REG_OPT:   cfg_rdata = {62'd0, opt_reg};
            REG_LOW:   cfg_rdata = {13'd0, low_reg};
            REG_MID:   cfg_rdata = {13'd0, mid_reg};
            REG_HIGH:  cfg_rdata = {30'd0, high_reg};
            default:   cfg_rdata = '0;
        endcase
    end

    // State of the model.
    logic [7:0]  mask_reg;
    logic        lat_reg, mom_reg, prev_reg, pend_reg, loaded_reg;
    logic [4:0]  last_hour_reg;
    logic [7:0]  step_reg;
    logic [15:0] ack_day_reg [8];
    logic [16:0] ack_sec_reg [8];

    // Captured word and working values.
    in_word_t    w_reg;
    logic [16:0] sod_reg;
    logic        restore_reg;
    logic [16:0] rem_reg;
    logic [4:0]  hour_reg;
    out_word_t   out_reg;

    logic [16:0] sod_in;
    assign sod_in = (in_word.second_of_day >= SEC_PER_DAY) ?
                    in_word.second_of_day - SEC_PER_DAY : in_word.second_of_day;

    // Slot time select for the scanned slot.
    logic [16:0] st;
    always_comb begin
        case (cmd.scan_idx)
            3'd0: st = low_reg[16:0];
            3'd1: st = low_reg[33:17];
            3'd2: st = low_reg[50:34];
            3'd3: st = mid_reg[16:0];
            3'd4: st = mid_reg[33:17];
            3'd5: st = mid_reg[50:34];
            3'd6: st = high_reg[16:0];
            default: st = high_reg[33:17];
        endcase
    end

    logic any_act;
    assign any_act = (mask_reg != 0) || lat_reg || mom_reg;

    // Hour by repeated subtraction, one hour per cycle.
    logic hour_step;
    assign hour_step = (rem_reg >= 17'(SEC_PER_HOUR));
    assign sts.hour_done = !hour_step;

    // Finish-step combinational result. By now rem_reg holds the seconds past
    // the hour, so a zero remainder marks a whole hour for the chime arm test.
    logic [7:0]  f_mask;
    logic        f_lat, f_mom, f_prev, f_pend, f_restore;
    logic [4:0]  f_last;
    logic [7:0]  f_step;
    out_word_t   f_out;
    logic [4:0]  hr;
    logic [2:0]  sh;
    logic [4:0]  hbits;
    logic [7:0]  nstep;
    always_comb begin
        f_mask = mask_reg; f_lat = lat_reg; f_mom = mom_reg; f_prev = prev_reg;
        f_pend = pend_reg || (w_reg.rtc_valid && opt_reg[0] && rem_reg == 17'd0);
        f_last = last_hour_reg; f_step = step_reg;
        f_restore = restore_reg;
        f_out = '0;
        hr = hour_reg;
        sh = 3'(step_reg[7:1] > 7'd6 ? 7'd6 : step_reg[7:1]);
        hbits = '0;
        nstep = step_reg;
        if (prev_reg != w_reg.momentary_pin) begin
            f_prev = w_reg.momentary_pin;
            f_mom  = w_reg.momentary_pin;
            if (!f_mom && mask_reg == 0 && !lat_reg) f_restore = 1'b1;
        end
        if (w_reg.latching_pin) f_lat = 1'b1;
        if (!w_reg.external_control) begin
            if (f_mask != 0 || f_lat || f_mom) begin
                if (beeps != 0) begin
                    f_pend = 1'b0;
                    if (32'(step_reg) >= MELODY_LENGTH) nstep = '0;
                    f_out.tone_request = 1'b1;
                    f_out.tone_code = melody_code(nstep[3:0]);
                    f_out.tone_duration_ms = melody_ms(nstep[3:0]);
                    f_step = w_reg.tone_ready ? nstep + 8'd1 : nstep;
                end
                if (blinks != 0) begin
                    f_out.force_bright = 1'b1;
                    f_out.blank_display = w_reg.blink_phase;
                end
            end else if (f_pend) begin
                if (opt_reg[1]) begin
                    if (hour_reg == 5'd0) hr = 5'd12;
                    else if (hour_reg > 5'd12) hr = hour_reg - 5'd12;
                end
                if (hr == last_hour_reg) begin
                    f_pend = 1'b0;
                end else if (hr == 5'd0) begin
                    f_out.tone_request = 1'b1;
                    f_out.tone_code = TONE_E6;
                    f_out.tone_duration_ms = CHIME_MS;
                    f_step = '0; f_last = hr; f_pend = 1'b0;
                end else begin
                    hbits = (sh < 3'd6) ? (hr >> sh) : 5'd0;
                    if (hbits != 0) begin
                        f_out.tone_request = 1'b1;
                        f_out.tone_duration_ms = CHIME_MS;
                        f_out.tone_code = step_reg[0] ? TONE_PAUSE :
                                          (hbits[0] ? TONE_E7 : TONE_E6);
                        if (w_reg.tone_ready) f_step = step_reg + 8'd1;
                    end else begin
                        f_step = '0; f_last = hr; f_pend = 1'b0;
                    end
                end
            end else begin
                f_step = '0;
            end
        end
        f_out.alarm_active = (f_mask != 0) || f_lat || f_mom;
        f_out.fired_slots = f_mask;
        f_out.restore_display = f_restore;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0; lat_reg <= 1'b0; mom_reg <= 1'b0; prev_reg <= 1'b0;
            pend_reg <= 1'b1; last_hour_reg <= NO_HOUR; step_reg <= '0;
            loaded_reg <= 1'b0;
        end else begin
            if (cmd.pre) begin
                if (!loaded_reg) loaded_reg <= 1'b1;
                if (w_reg.clear_request && any_act) begin
                    mask_reg <= '0; lat_reg <= 1'b0; mom_reg <= 1'b0; step_reg <= '0;
                end
            end
            if (cmd.scan && w_reg.rtc_valid && (beeps[cmd.scan_idx] || blinks[cmd.scan_idx])
                && sod_reg >= st
                && (ack_day_reg[cmd.scan_idx] < w_reg.day_number
                    || (ack_day_reg[cmd.scan_idx] == w_reg.day_number
                        && ack_sec_reg[cmd.scan_idx] < st)))
                mask_reg[cmd.scan_idx] <= 1'b1;
            if (cmd.fin) begin
                mask_reg <= f_mask; lat_reg <= f_lat; mom_reg <= f_mom; prev_reg <= f_prev;
                pend_reg <= f_pend; last_hour_reg <= f_last; step_reg <= f_step;
            end
        end
    end

    // The hour divider starts from the folded time of day in the load cycle and
    // leaves the quotient in hour_reg and the remainder in rem_reg.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            w_reg       <= in_word;
            sod_reg     <= sod_in;
            rem_reg     <= sod_in;
            hour_reg    <= '0;
            restore_reg <= 1'b0;
        end
        if (cmd.pre) begin
            // Per-slot acknowledge stamps: first-word load, then clear stamping.
            for (int i = 0; i < 8; i++) begin
                if (!loaded_reg || (w_reg.clear_request && any_act && mask_reg[i])) begin
                    ack_day_reg[i] <= w_reg.day_number;
                    ack_sec_reg[i] <= sod_reg;
                end
            end
            if (w_reg.clear_request && any_act) restore_reg <= 1'b1;
        end
        if (cmd.hour && hour_step) begin
            rem_reg  <= rem_reg - 17'(SEC_PER_HOUR);
            hour_reg <= hour_reg + 5'd1;
        end
        if (cmd.fin) out_reg <= f_out;
    end
    assign out_word = out_reg;
endmodule

>>> sv/alarm_slot_and_chime_controller_core.sv
// Top level of the alarm slot and chime controller: APB register port, word
// handshakes, controller and datapath. Uses ascc_pkg, ascc_ctrl and ascc_dp.
//
// Use: each firmware tick one input word (clock, pins, key, tone-ready, blink
// phase) is offered on s_valid/s_ready; one result word (tone request, alarm
// flags, display commands) comes back on m_valid/m_ready. Registers are set
// through the APB port at byte address 8*i, 64-bit data, pready always high.
// After acceptance a word goes through load, stamp/clear, the slot scan, hour
// division and finish before m_valid rises. The hour is found by one
// subtraction of 3600 seconds per cycle and the slots are compared one per
// cycle. One word is in work at a time, and s_ready is low from acceptance
// until the result is taken. While m_ready is low the result holds and no new
// word is taken.
// After reset the chime is armed (start-up beep), all alarms are idle and the
// acknowledge stamps are loaded from the first word.
module alarm_slot_and_chime_controller_core #(
    parameter int SLOT_COUNT    = ascc_pkg::SLOT_COUNT_DEF,
    parameter int EXT_COUNT     = ascc_pkg::EXT_COUNT_DEF,
    parameter int MELODY_LENGTH = ascc_pkg::MELODY_LENGTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ascc_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ascc_pkg::out_word_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import ascc_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic busy;

    assign pready  = 1'b1;
    assign s_ready = !busy;

    ascc_ctrl #(.SLOT_COUNT(SLOT_COUNT)) u_ctrl (
        .aclk, .aresetn,
        .in_fire(s_valid && s_ready),
        .out_fire(m_valid && m_ready),
        .sts, .cmd, .busy, .out_valid(m_valid)
    );

    ascc_dp #(
        .SLOT_COUNT(SLOT_COUNT), .EXT_COUNT(EXT_COUNT), .MELODY_LENGTH(MELODY_LENGTH)
    ) u_dp (
        .aclk, .aresetn, .cmd, .sts,
        .in_word(s_data),
        .cfg_we(psel && penable && pwrite),
        .cfg_idx(paddr[5:3]),
        .cfg_wdata(pwdata),
        .cfg_rdata(prdata),
        .out_word(m_data)
    );
endmodule

>>> sv/ascc_checker.sv
// Port-level checker for the alarm controller, bound to the top level.
// Uses ascc_pkg.
module ascc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input ascc_pkg::out_word_t m_data
);
    import ascc_pkg::*;

    // One word in work at a time: input closed while a result is shown.
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input open with result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped while stalled");

    a_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.tone_request |->
            m_data.tone_code == TONE_REST && m_data.tone_duration_ms == 10'd0)
        else $error("tone fields set without request");

    a_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.fired_slots != 8'd0 |-> m_data.alarm_active)
        else $error("fired slot without active alarm");

    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid) else $error("result too early");
endmodule

bind alarm_slot_and_chime_controller_core ascc_checker u_ascc_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);

>>> tb/alarm_slot_and_chime_controller_core_tb.sv
// Testbench for the alarm slot and chime controller core: a directed table, then
// random ticks, all checked against a behavioral model of slots, alarms and chime.
// Depends on ascc_pkg and alarm_slot_and_chime_controller_core.
module alarm_slot_and_chime_controller_core_tb;
    import ascc_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [5:0] paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic pready;

    alarm_slot_and_chime_controller_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Model state and registers.
    logic [9:0] mdl_beep, mdl_blink;
    logic [1:0] mdl_opt;
    logic [50:0] mdl_low, mdl_mid;
    logic [33:0] mdl_high;
    logic [7:0] mdl_active;
    logic mdl_latched, mdl_mom, mdl_prev_mom, mdl_chime;
    logic [4:0] mdl_last_hour;
    logic [7:0] mdl_step;
    logic [15:0] mdl_ack_day[8];
    logic [16:0] mdl_ack_sec[8];
    logic mdl_loaded;

    out_word_t expected_words[$];
    int errors = 0;
    int cycles = 0;
    logic hold_off = 1'b0;

    function automatic logic [16:0] slot_time_of(int i);
        if (i < 3) return mdl_low[17*i +: 17];
        if (i < 6) return mdl_mid[17*(i-3) +: 17];
        return mdl_high[17*(i-6) +: 17];
    endfunction

    function automatic logic [2:0] note_code(int i);
        logic [2:0] codes[10] = '{3'd6, 3'd3, TONE_REST, 3'd3, 3'd4, 3'd3, TONE_REST, 3'd5,
                                 3'd6, TONE_REST};
        return codes[i];
    endfunction

    function automatic logic [9:0] note_ms(int i);
        logic [9:0] lens[10] = '{10'd150, 10'd300, 10'd50, 10'd300, 10'd150, 10'd150,
                                10'd150, 10'd150, 10'd150, 10'd700};
        return lens[i];
    endfunction

    task automatic predict_tick(input in_word_t w, output out_word_t r);
        logic [16:0] sod, st;
        int hour, sh, bits;
        logic any;
        r = '0;
        sod = w.second_of_day;
        if (sod >= 17'd86400) sod = sod - 17'd86400;
        if (!mdl_loaded) begin
            for (int i = 0; i < 8; i++) begin
                mdl_ack_day[i] = w.day_number;
                mdl_ack_sec[i] = sod;
            end
            mdl_loaded = 1'b1;
        end
        if (w.clear_request && (mdl_active != 0 || mdl_latched || mdl_mom)) begin
            for (int i = 0; i < 8; i++) begin
                if (mdl_active[i]) begin
                    mdl_ack_day[i] = w.day_number;
                    mdl_ack_sec[i] = sod;
                end
            end
            mdl_active = '0;
            mdl_latched = 1'b0;
            mdl_mom = 1'b0;
            mdl_step = '0;
            r.restore_display = 1'b1;
        end
        if (w.rtc_valid) begin
            if (mdl_opt[0] && (sod % 3600) == 0) mdl_chime = 1'b1;
            for (int i = 0; i < 8; i++) begin
                if (mdl_beep[i] || mdl_blink[i]) begin
                    st = slot_time_of(i);
                    if (sod >= st && (mdl_ack_day[i] < w.day_number ||
                        (mdl_ack_day[i] == w.day_number && mdl_ack_sec[i] < st)))
                        mdl_active[i] = 1'b1;
                end
            end
        end
        if (mdl_prev_mom != w.momentary_pin) begin
            mdl_prev_mom = w.momentary_pin;
            mdl_mom = w.momentary_pin;
            if (!mdl_mom && mdl_active == 0 && !mdl_latched) r.restore_display = 1'b1;
        end
        if (w.latching_pin) mdl_latched = 1'b1;
        any = (mdl_active != 0) || mdl_latched || mdl_mom;
        if (!w.external_control) begin
            if (any) begin
                if (mdl_beep != 0) begin
                    mdl_chime = 1'b0;
                    if (mdl_step >= 10) mdl_step = '0;
                    r.tone_request = 1'b1;
                    r.tone_code = note_code(mdl_step);
                    r.tone_duration_ms = note_ms(mdl_step);
                    if (w.tone_ready) mdl_step++;
                end
                if (mdl_blink != 0) begin
                    r.force_bright = 1'b1;
                    r.blank_display = w.blink_phase;
                end
            end else if (mdl_chime) begin
                hour = sod / 3600;
                if (mdl_opt[1]) begin
                    if (hour == 0) hour = 12;
                    else if (hour > 12) hour -= 12;
                end
                if (hour == mdl_last_hour) begin
                    mdl_chime = 1'b0;
                end else if (hour == 0) begin
                    r.tone_request = 1'b1;
                    r.tone_code = TONE_E6;
                    r.tone_duration_ms = CHIME_MS;
                    mdl_step = '0;
                    mdl_last_hour = 5'(hour);
                    mdl_chime = 1'b0;
                end else begin
                    sh = mdl_step >> 1;
                    bits = (sh < 6) ? (hour >> sh) : 0;
                    if (bits > 0) begin
                        r.tone_request = 1'b1;
                        r.tone_duration_ms = CHIME_MS;
                        r.tone_code = mdl_step[0] ? TONE_PAUSE : (bits[0] ? TONE_E7 : TONE_E6);
                        if (w.tone_ready) mdl_step++;
                    end else begin
                        mdl_step = '0;
                        mdl_last_hour = 5'(hour);
                        mdl_chime = 1'b0;
                    end
                end
            end else begin
                mdl_step = '0;
            end
        end
        r.alarm_active = any;
        r.fired_slots = mdl_active;
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        out_word_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected word", 16'(m_data.fired_slots), 16'h0);
            end else begin
                e = expected_words.pop_front();
                if (m_data.tone_request !== e.tone_request)
                    report_mismatch("tone_request", 16'(m_data.tone_request),
                                    16'(e.tone_request));
                if (m_data.tone_code !== e.tone_code)
                    report_mismatch("tone_code", 16'(m_data.tone_code), 16'(e.tone_code));
                if (m_data.tone_duration_ms !== e.tone_duration_ms)
                    report_mismatch("tone_duration_ms", 16'(m_data.tone_duration_ms),
                                    16'(e.tone_duration_ms));
                if (m_data.alarm_active !== e.alarm_active)
                    report_mismatch("alarm_active", 16'(m_data.alarm_active),
                                    16'(e.alarm_active));
                if (m_data.fired_slots !== e.fired_slots)
                    report_mismatch("fired_slots", 16'(m_data.fired_slots),
                                    16'(e.fired_slots));
                if (m_data.blank_display !== e.blank_display)
                    report_mismatch("blank_display", 16'(m_data.blank_display),
                                    16'(e.blank_display));
                if (m_data.force_bright !== e.force_bright)
                    report_mismatch("force_bright", 16'(m_data.force_bright),
                                    16'(e.force_bright));
                if (m_data.restore_display !== e.restore_display)
                    report_mismatch("restore_display", 16'(m_data.restore_display),
                                    16'(e.restore_display));
            end
        end
    end

    // Receiver: random stalls per word, plus a long hold-off when asked.
    always @(posedge aclk) begin
        int gap;
        if (aresetn) begin
            if (hold_off) begin
                m_ready <= 1'b0;
            end else if (!m_ready) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                repeat (gap) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (m_valid) begin
                if ($urandom_range(0, 2) != 0) m_ready <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_BEEP: mdl_beep = value[9:0];
            REG_BLINK: mdl_blink = value[9:0];
            REG_OPT: mdl_opt = value[1:0];
            REG_LOW: mdl_low = value[50:0];
            REG_MID: mdl_mid = value[50:0];
            default: mdl_high = value[33:0];
        endcase
    endtask

    // Valid stays high after an accepted word when the next one follows at once;
    // otherwise it drops for the gap.
    task automatic send_word(input in_word_t w, input logic check_fixed,
                             input out_word_t fixed);
        out_word_t r;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        predict_tick(w, r);
        if (check_fixed && r !== fixed)
            report_mismatch("directed table", 16'(r.fired_slots), 16'(fixed.fired_slots));
        expected_words.push_back(r);
        s_data <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        // No word is in flight once every expected result is taken, so
        // this only settles the pipeline before a register write.
        repeat (40) @(posedge aclk);
    endtask

    function automatic in_word_t tick_word(logic rv, logic [15:0] d, logic [16:0] s,
                                           logic [6:0] pins);
        in_word_t w;
        w.rtc_valid = rv;
        w.day_number = d;
        w.second_of_day = s;
        {w.latching_pin, w.momentary_pin, w.clear_request, w.external_control,
         w.tone_ready, w.blink_phase} = pins[5:0];
        return w;
    endfunction

    function automatic logic [63:0] rand_slots(int n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++) v[17*i +: 17] = 17'($urandom_range(0, 86399));
        return v;
    endfunction

    typedef struct {
        in_word_t stim;
        logic known;
        out_word_t want;
    } dir_row_t;

    initial begin
        dir_row_t rows[$];
        out_word_t fixed;
        in_word_t w;
        logic [15:0] day;
        logic [16:0] sod;
        mdl_beep = '0; mdl_blink = '0; mdl_opt = '0;
        mdl_low = '0; mdl_mid = '0; mdl_high = '0;
        mdl_active = '0; mdl_latched = 1'b0; mdl_mom = 1'b0; mdl_prev_mom = 1'b0;
        mdl_chime = 1'b1; mdl_last_hour = NO_HOUR; mdl_step = '0; mdl_loaded = 1'b0;
        for (int i = 0; i < 8; i++) begin
            mdl_ack_day[i] = '0;
            mdl_ack_sec[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. After reset at midnight the start-up beep is the zero-hour tone.
        fixed = '0;
        fixed.tone_request = 1'b1;
        fixed.tone_code = TONE_E6;
        fixed.tone_duration_ms = CHIME_MS;
        rows.push_back('{tick_word(1, 16'd0, 17'd0, 7'b0000010), 1'b1, fixed});
        fixed = '0;
        rows.push_back('{tick_word(1, 16'hFFFF, 17'h1FFFF, 7'b0000111), 1'b1, fixed});
        // Clear with nothing active is ignored.
        rows.push_back('{tick_word(0, 16'd5, 17'd86399, 7'b0001000), 1'b1, fixed});
        foreach (rows[i]) send_word(rows[i].stim, rows[i].known, rows[i].want);
        wait_idle();

        write_reg(REG_BEEP, 64'h3FF);
        write_reg(REG_BLINK, 64'h3FF);
        write_reg(REG_OPT, 64'h3);
        write_reg(REG_LOW, {13'd0, 17'd200, 17'd100, 17'd0});
        write_reg(REG_MID, {13'd0, 17'd86399, 17'd43200, 17'd3600});
        write_reg(REG_HIGH, {30'd0, 17'd7200, 17'd500});
        rows.delete();
        rows.push_back('{tick_word(1, 16'd1, 17'd3600, 7'b0000011), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd1, 17'd3700, 7'b0000010), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd1, 17'd3800, 7'b0001011), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd1, 17'd3900, 7'b0100010), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd1, 17'd3901, 7'b0000110), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd1, 17'd3902, 7'b0010011), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd1, 17'd3903, 7'b0000010), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd1, 17'd3904, 7'b0001010), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd2, 17'd86400, 7'b0000000), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd2, 17'd131071, 7'b0001010), 1'b0, fixed});
        rows.push_back('{tick_word(1, 16'd3, 17'd82800, 7'b0001010), 1'b0, fixed});
        for (int k = 0; k < 14; k++)
            rows.push_back('{tick_word(1, 16'd3, 17'd82800 + 17'(k), 7'b0000010 | 7'(k[0])),
                             1'b0, fixed});
        foreach (rows[i]) send_word(rows[i].stim, rows[i].known, rows[i].want);
        wait_idle();

        // Random part in phases of different settings.
        day = 16'd10;
        sod = 17'd0;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_BEEP, 64'h0);
                    write_reg(REG_BLINK, 64'h0);
                    write_reg(REG_OPT, 64'h1);
                end
                1: begin
                    write_reg(REG_BEEP, 64'($urandom_range(0, 1023)));
                    write_reg(REG_BLINK, 64'($urandom_range(0, 1023)));
                    write_reg(REG_OPT, 64'($urandom_range(0, 3)));
                end
                default: begin
                    write_reg(REG_BEEP, 64'($urandom_range(0, 1023)));
                    write_reg(REG_BLINK, 64'($urandom_range(0, 1023)));
                    write_reg(REG_OPT, 64'($urandom_range(0, 3)));
                    write_reg(REG_LOW, {$urandom, $urandom});
                    write_reg(REG_MID, rand_slots(3));
                    write_reg(REG_HIGH, rand_slots(2));
                end
            endcase
            if (ph == 2) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 140; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    w.rtc_valid = 1'($urandom_range(0, 1));
                    w.day_number = 16'($urandom);
                    w.second_of_day = 17'($urandom);
                end else begin
                    // Mostly a clock that moves forward, often across hours.
                    case ($urandom_range(0, 3))
                        0: sod = sod + 17'd1;
                        1: sod = sod + 17'($urandom_range(1, 600));
                        2: sod = (sod / 17'd3600 + 17'd1) * 17'd3600;
                        default: sod = sod + 17'($urandom_range(1, 7200));
                    endcase
                    if (sod >= 17'd86400) begin
                        sod = sod - 17'd86400;
                        day = day + 16'd1;
                    end
                    w.rtc_valid = ($urandom_range(0, 15) != 0);
                    w.day_number = day;
                    w.second_of_day = sod;
                end
                w.latching_pin = ($urandom_range(0, 19) == 0);
                w.momentary_pin = ($urandom_range(0, 7) == 0) ? ~mdl_prev_mom : mdl_prev_mom;
                w.clear_request = ($urandom_range(0, 7) == 0);
                w.external_control = ($urandom_range(0, 9) == 0);
                w.tone_ready = ($urandom_range(0, 4) != 0);
                w.blink_phase = 1'($urandom_range(0, 1));
                send_word(w, 1'b0, fixed);
            end
            wait_idle();
        end

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Leftover expectations are caught by the idle wait above never ending
    // within the cycle limit.
endmodule
